// File: src/box_qp_projected_gradient_solver_macros.svh
// Assertion macros for the box QP solver
`ifndef BOX_QP_PROJECTED_GRADIENT_SOLVER_MACROS_SVH
`define BOX_QP_PROJECTED_GRADIENT_SOLVER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define BQPG_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define BQPG_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BQPG_ASSERT_IMP(lbl, ante, cons)
`define BQPG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/bqpg_pkg.sv
`timescale 1ns / 1ps
package bqpg_pkg;

   // number of variables the ring holds, matched to the 4-bit index fields
   localparam int MAX_SIZE = 16;

   // input opcodes
   localparam logic [1:0] OP_HESS  = 2'd0;
   localparam logic [1:0] OP_VEC   = 2'd1;
   localparam logic [1:0] OP_SOLVE = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_STEP  = 2'd0;
   localparam logic [1:0] CSR_LIMIT = 2'd1;
   localparam logic [1:0] CSR_TOL   = 2'd2;
   localparam logic [1:0] CSR_SIZE  = 2'd3;

   // per-cycle commands from the sequencer to every cell
   typedef struct packed {
      logic start;  // load own estimate into the token, preload accumulator
      logic shift;  // pass token to the neighbour
      logic mac;    // multiply H entry by token
      logic acc;    // add floored product
      logic grad;   // saturate gradient
      logic step;   // step times gradient
      logic upd;    // new estimate, change and magnitude
      logic red;    // max reduction along the chain
   } ctrl_type;

endpackage

// File: src/box_qp_projected_gradient_solver.sv
`timescale 1ns / 1ps
// Box-constrained QP solver, projected gradient, signed fixed point.
// Load items (Hessian entry or per-variable vector entry) are taken only while idle.
// A solve runs on a ring of MAX_SIZE cells, one per variable, each holding its
// H row: estimates circulate round the ring, and an iteration runs a start step,
// one multiply-accumulate per variable, the drain, gradient, step and update
// pipeline steps, a max reduction along the chain and the check steps. The n
// results are then loaded into the ring and leave one per transfer. No new item
// is taken until the last result of a solve has been transferred.
`include "box_qp_projected_gradient_solver_macros.svh"
module box_qp_projected_gradient_solver import bqpg_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [31:0] req_hessian_value,
   input  logic signed [31:0] req_linear_value,
   input  logic signed [31:0] req_lower_value,
   input  logic signed [31:0] req_upper_value,
   input  logic signed [31:0] req_start_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_var_index,
   output logic signed [31:0] rsp_solution_value,
   output logic               rsp_last,
   output logic               rsp_converged,
   output logic [15:0]        rsp_iterations,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int NW    = $clog2(MAX_SIZE + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_MAC    = 4'd2;
   localparam logic [3:0] S_DRAIN  = 4'd3;
   localparam logic [3:0] S_GRAD   = 4'd4;
   localparam logic [3:0] S_STEP   = 4'd5;
   localparam logic [3:0] S_UPD    = 4'd6;
   localparam logic [3:0] S_RED    = 4'd7;
   localparam logic [3:0] S_CHK1   = 4'd8;
   localparam logic [3:0] S_CHK2   = 4'd9;
   localparam logic [3:0] S_DECIDE = 4'd10;
   localparam logic [3:0] S_OUTL   = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [30:0] step_ff, tol_ff;
   logic [15:0] limit_ff;
   logic [4:0]  size_ff;

   logic [3:0]    state_ff, state_in;
   logic [NW-1:0] cnt_ff, cnt_in, n_eff, n_last;
   logic [15:0]   it_ff, it_in, limit_eff;
   logic          conv_ff, conv_in;
   logic [63:0]   lhs_ff, rhs_ff;
   logic [31:0]   sum_ff;
   ctrl_type      ctrl;
   logic          req_xfer, rsp_xfer, row_ok, col_ok;

   logic signed [31:0] tok_x [MAX_SIZE];
   logic [IDX_W-1:0]   tok_i [MAX_SIZE];
   logic [31:0]        dmax  [MAX_SIZE];
   logic [31:0]        mmax  [MAX_SIZE];

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 31'd6554;
         limit_ff <= 16'd100;
         tol_ff   <= 31'd66;
         size_ff  <= 5'd16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STEP:  step_ff  <= csr_data[30:0];
            CSR_LIMIT: limit_ff <= csr_data[15:0];
            CSR_TOL:   tol_ff   <= csr_data[30:0];
            CSR_SIZE:  size_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // effective problem size and limit
   always_comb begin
      if (size_ff == 5'd0) begin
         n_eff = NW'(1);
      end else if (32'(size_ff) > MAX_SIZE) begin
         n_eff = NW'(MAX_SIZE);
      end else begin
         n_eff = NW'(size_ff);
      end
      n_last    = n_eff - NW'(1);
      limit_eff = (limit_ff == 16'd0) ? 16'd1 : limit_ff;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign row_ok    = 32'(req_row_index) < MAX_SIZE;
   assign col_ok    = 32'(req_col_index) < MAX_SIZE;

   // cell commands
   always_comb begin
      ctrl.start = (state_ff == S_START) || (state_ff == S_OUTL);
      ctrl.shift = (state_ff == S_MAC) || rsp_xfer;
      ctrl.mac   = (state_ff == S_MAC);
      ctrl.acc   = ((state_ff == S_MAC) && (cnt_ff != '0)) || (state_ff == S_DRAIN);
      ctrl.grad  = (state_ff == S_GRAD);
      ctrl.step  = (state_ff == S_STEP);
      ctrl.upd   = (state_ff == S_UPD);
      ctrl.red   = (state_ff == S_RED);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      it_in    = it_ff;
      conv_in  = conv_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_opcode == OP_SOLVE) begin
               state_in = S_START;
               it_in    = 16'd1;
               conv_in  = 1'b0;
            end
         end
         S_START: begin
            state_in = S_MAC;
            cnt_in   = '0;
         end
         S_MAC: begin
            if (cnt_ff == n_last) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         S_DRAIN: state_in = S_GRAD;
         S_GRAD:  state_in = S_STEP;
         S_STEP:  state_in = S_UPD;
         S_UPD: begin
            state_in = S_RED;
            cnt_in   = '0;
         end
         S_RED: begin
            if (cnt_ff == n_last) begin
               state_in = S_CHK1;
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         S_CHK1: state_in = S_CHK2;
         S_CHK2: state_in = S_DECIDE;
         S_DECIDE: begin
            if (lhs_ff <= rhs_ff) begin
               conv_in  = 1'b1;
               state_in = S_OUTL;
            end else if (it_ff == limit_eff) begin
               state_in = S_OUTL;
            end else begin
               it_in    = it_ff + 16'd1;
               state_in = S_START;
            end
         end
         S_OUTL: begin
            state_in = S_OUT;
            cnt_in   = '0;
         end
         S_OUT: begin
            if (rsp_xfer) begin
               if (cnt_ff == n_last) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + NW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         it_ff    <= 16'd0;
         conv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         it_ff    <= it_in;
         conv_ff  <= conv_in;
      end
   end

   // convergence test: change * 2^F <= tol * (2^F + magnitude)
   always_ff @(posedge clock) begin
      if (state_ff == S_CHK1) begin
         lhs_ff <= 64'(dmax[0]) << FRAC_BITS;
         sum_ff <= (32'd1 << FRAC_BITS) + mmax[0];
      end
      if (state_ff == S_CHK2) begin
         rhs_ff <= 64'(tol_ff) * 64'(sum_ff);
      end
   end

   // ring of cells
   for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
      logic signed [31:0] nbx;
      logic [IDX_W-1:0]   nbi;
      logic [31:0]        nbd, nbm;
      logic               hwe, vwe;

      assign hwe = req_xfer && req_opcode == OP_HESS && row_ok && col_ok
                   && 32'(req_row_index) == k;
      assign vwe = req_xfer && req_opcode == OP_VEC && row_ok
                   && 32'(req_row_index) == k;

      if (k == MAX_SIZE - 1) begin : g_tail
         assign nbx = tok_x[0];
         assign nbi = tok_i[0];
         assign nbd = 32'd0;
         assign nbm = 32'd0;
      end else begin : g_mid
         assign nbx = (32'(n_last) == k) ? tok_x[0] : tok_x[k+1];
         assign nbi = (32'(n_last) == k) ? tok_i[0] : tok_i[k+1];
         assign nbd = dmax[k+1];
         assign nbm = mmax[k+1];
      end

      bqpg_cell #(
         .FRAC_BITS (FRAC_BITS),
         .K         (k)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .step_size (step_ff),
         .size_n    (n_eff),
         .hw_en     (hwe),
         .vw_en     (vwe),
         .wr_col    (IDX_W'(req_col_index)),
         .h_data    (req_hessian_value),
         .q_data    (req_linear_value),
         .lo_data   (req_lower_value),
         .hi_data   (req_upper_value),
         .x_data    (req_start_value),
         .nb_x      (nbx),
         .nb_i      (nbi),
         .nb_d      (nbd),
         .nb_m      (nbm),
         .tok_x     (tok_x[k]),
         .tok_i     (tok_i[k]),
         .dmax      (dmax[k]),
         .mmax      (mmax[k])
      );
   end

   // results leave from the head cell
   assign rsp_var_index      = 4'(cnt_ff);
   assign rsp_solution_value = tok_x[0];
   assign rsp_last           = (cnt_ff == n_last);
   assign rsp_converged      = conv_ff;
   assign rsp_iterations     = it_ff;

   `BQPG_ASSERT_IMP(a_busy_out, rsp_valid, req_stall)
   `BQPG_ASSERT_NXT(a_last_ends, rsp_xfer && rsp_last, !rsp_valid)
   `BQPG_ASSERT_NXT(a_solve_busy, req_xfer && req_opcode == OP_SOLVE, req_stall)
   `BQPG_ASSERT_IMP(a_iter_nz, rsp_valid, rsp_iterations != 16'd0)
endmodule

// File: src/bqpg_cell.sv
`timescale 1ns / 1ps
module bqpg_cell import bqpg_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int K         = 0
) (
   input  logic                                clock,
   input  ctrl_type                            ctrl,
   input  logic [30:0]                         step_size,
   input  logic [$clog2(MAX_SIZE+1)-1:0]       size_n,
   input  logic                                hw_en,
   input  logic                                vw_en,
   input  logic [(MAX_SIZE>1 ? $clog2(MAX_SIZE) : 1)-1:0] wr_col,
   input  logic signed [31:0]                  h_data,
   input  logic signed [31:0]                  q_data,
   input  logic signed [31:0]                  lo_data,
   input  logic signed [31:0]                  hi_data,
   input  logic signed [31:0]                  x_data,
   input  logic signed [31:0]                  nb_x,
   input  logic [(MAX_SIZE>1 ? $clog2(MAX_SIZE) : 1)-1:0] nb_i,
   input  logic [31:0]                         nb_d,
   input  logic [31:0]                         nb_m,
   output logic signed [31:0]                  tok_x,
   output logic [(MAX_SIZE>1 ? $clog2(MAX_SIZE) : 1)-1:0] tok_i,
   output logic [31:0]                         dmax,
   output logic [31:0]                         mmax
);
   localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int ACC_W = 64 - FRAC_BITS + $clog2(MAX_SIZE + 1);
   localparam int SW    = 65 - FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(32'sh7fffffff);
   localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-64'sh80000000);
   localparam logic signed [SW-1:0]    S_HI   = SW'(32'sh7fffffff);
   localparam logic signed [SW-1:0]    S_LO   = SW'(-64'sh80000000);

   // row of H held by this cell
   logic signed [31:0] hrow [MAX_SIZE];

   logic signed [31:0]      q_ff, lo_ff, hi_ff, x_ff, tx_ff, h_ff, g_ff;
   logic [IDX_W-1:0]        ti_ff;
   logic signed [63:0]      prod_ff, sp_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [31:0]             dmax_ff, mmax_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic signed [SW-1:0]    diff;
   logic signed [31:0]      vsat, vnew;
   logic signed [32:0]      dch;
   logic [31:0]             dabs, mabs;
   logic                    active;

   assign rd_addr = ctrl.start ? IDX_W'(K) : nb_i;
   assign active  = 32'(size_n) > K;

   // H row memory, registered read of the incoming token's column
   always_ff @(posedge clock) begin
      if (hw_en) begin
         hrow[wr_col] <= h_data;
      end
      h_ff <= hrow[rd_addr];
   end

   // new estimate: saturate, then clamp with the lower bound first
   always_comb begin
      diff = SW'(x_ff) - SW'(sp_ff >>> FRAC_BITS);
      if (diff > S_HI) begin
         vsat = 32'sh7fffffff;
      end else if (diff < S_LO) begin
         vsat = -32'sh80000000;
      end else begin
         vsat = 32'(diff);
      end
      if (vsat < lo_ff) begin
         vnew = lo_ff;
      end else if (vsat > hi_ff) begin
         vnew = hi_ff;
      end else begin
         vnew = vsat;
      end
      dch  = 33'(vnew) - 33'(x_ff);
      dabs = dch[32] ? 32'(-dch) : 32'(dch);
      mabs = x_ff[31] ? 32'(-33'(x_ff)) : 32'(x_ff);
   end

   // datapath
   always_ff @(posedge clock) begin
      if (vw_en) begin
         q_ff  <= q_data;
         lo_ff <= lo_data;
         hi_ff <= hi_data;
      end
      // cells beyond the problem size keep their estimate
      if (vw_en) begin
         x_ff <= x_data;
      end else if (ctrl.upd && active) begin
         x_ff <= vnew;
      end
      if (ctrl.start) begin
         tx_ff <= x_ff;
         ti_ff <= IDX_W'(K);
      end else if (ctrl.shift) begin
         tx_ff <= nb_x;
         ti_ff <= nb_i;
      end
      if (ctrl.mac) begin
         prod_ff <= 64'(h_ff) * 64'(tx_ff);
      end
      if (ctrl.start) begin
         acc_ff <= ACC_W'(q_ff);
      end else if (ctrl.acc) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff >>> FRAC_BITS);
      end
      if (ctrl.grad) begin
         if (acc_ff > ACC_HI) begin
            g_ff <= 32'sh7fffffff;
         end else if (acc_ff < ACC_LO) begin
            g_ff <= -32'sh80000000;
         end else begin
            g_ff <= 32'(acc_ff);
         end
      end
      if (ctrl.step) begin
         sp_ff <= 64'($signed({1'b0, step_size})) * 64'(g_ff);
      end
      if (ctrl.upd) begin
         dmax_ff <= active ? dabs : 32'd0;
         mmax_ff <= active ? mabs : 32'd0;
      end else if (ctrl.red) begin
         dmax_ff <= (nb_d > dmax_ff) ? nb_d : dmax_ff;
         mmax_ff <= (nb_m > mmax_ff) ? nb_m : mmax_ff;
      end
   end

   assign tok_x = tx_ff;
   assign tok_i = ti_ff;
   assign dmax  = dmax_ff;
   assign mmax  = mmax_ff;
endmodule

// File: tb/sv/tb_box_qp_projected_gradient_solver.sv
`timescale 1ns / 1ps
module tb_box_qp_projected_gradient_solver;
   import bqpg_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int N_MAX = 16;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [1:0]         op;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] h;
      logic signed [31:0] q;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic signed [31:0] x;
   } qp_item_type;

   typedef struct {
      logic [3:0]         idx;
      logic signed [31:0] val;
      logic               last;
      logic               conv;
      logic [15:0]        iters;
   } solution_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_opcode;
   logic [3:0]         req_row_index;
   logic [3:0]         req_col_index;
   logic signed [31:0] req_hessian_value;
   logic signed [31:0] req_linear_value;
   logic signed [31:0] req_lower_value;
   logic signed [31:0] req_upper_value;
   logic signed [31:0] req_start_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [3:0]         rsp_var_index;
   logic signed [31:0] rsp_solution_value;
   logic               rsp_last;
   logic               rsp_converged;
   logic [15:0]        rsp_iterations;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [31:0]        csr_data;

   // shadow copy of the solver state
   logic signed [31:0] hess_shadow [N_MAX][N_MAX];
   logic signed [31:0] lin_shadow [N_MAX];
   logic signed [31:0] lo_shadow [N_MAX];
   logic signed [31:0] hi_shadow [N_MAX];
   logic signed [31:0] est_shadow [N_MAX];
   logic [30:0]        step_cfg;
   logic [15:0]        limit_cfg;
   logic [30:0]        tol_cfg;
   logic [4:0]         size_cfg;

   qp_item_type  pending_items [$];
   solution_type expected_solutions [$];
   qp_item_type  cur_item;
   bit        req_taken;
   bit        idle_on;
   int        req_gap;
   int        rsp_hold;
   int        mismatches;
   int        items_pushed;
   int        cycles;

   box_qp_projected_gradient_solver dut (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [31:0] sat32(longint a);
      if (a > 64'sd2147483647) return 32'sh7fffffff;
      if (a < -64'sd2147483648) return 32'sh80000000;
      return a[31:0];
   endfunction

   function automatic logic [63:0] mag64(longint a);
      return (a < 0) ? -a : a;
   endfunction

   // Jacobi projected gradient iterations over the shadow state
   function automatic void solve_predict();
      int n, lim, it, i, j;
      longint acc, x;
      logic signed [31:0] g, v;
      logic signed [31:0] nxt [N_MAX];
      logic [63:0] dmax, mmax, lhs, rhs;
      logic conv;
      logic [15:0] iters;
      solution_type s;
      n = (size_cfg == 0) ? 1 : ((size_cfg > N_MAX) ? N_MAX : size_cfg);
      lim = (limit_cfg == 0) ? 1 : limit_cfg;
      iters = 16'(lim);
      conv = 1'b0;
      for (it = 1; it <= lim && !conv; it++) begin
         dmax = 0;
         mmax = 0;
         for (i = 0; i < n; i++) begin
            acc = lin_shadow[i];
            x = est_shadow[i];
            for (j = 0; j < n; j++)
               acc += (longint'(hess_shadow[i][j]) * longint'(est_shadow[j])) >>> 16;
            g = sat32(acc);
            v = sat32(x - ((longint'(step_cfg) * longint'(g)) >>> 16));
            // lower bound first, so it wins when the bounds cross
            if (v < lo_shadow[i]) v = lo_shadow[i];
            else if (v > hi_shadow[i]) v = hi_shadow[i];
            nxt[i] = v;
            if (mag64(longint'(v) - x) > dmax) dmax = mag64(longint'(v) - x);
            if (mag64(x) > mmax) mmax = mag64(x);
         end
         for (i = 0; i < n; i++) est_shadow[i] = nxt[i];
         lhs = dmax << 16;
         rhs = {33'b0, tol_cfg} * (64'd65536 + mmax);
         if (lhs <= rhs) begin
            conv = 1'b1;
            iters = 16'(it);
         end
      end
      for (i = 0; i < n; i++) begin
         s.idx = 4'(i);
         s.val = est_shadow[i];
         s.last = (i == n - 1);
         s.conv = conv;
         s.iters = iters;
         expected_solutions.push_back(s);
      end
   endfunction

   function automatic void apply_item(qp_item_type it);
      case (it.op)
         OP_HESS: hess_shadow[it.row][it.col] = it.h;
         OP_VEC: begin
            lin_shadow[it.row] = it.q;
            lo_shadow[it.row] = it.lo;
            hi_shadow[it.row] = it.hi;
            est_shadow[it.row] = it.x;
         end
         OP_SOLVE: solve_predict();
         default: ;
      endcase
   endfunction

   // stimulus helpers
   task automatic push_item(logic [1:0] op, int row, int col, logic [31:0] h,
                            logic [31:0] q, logic [31:0] lo, logic [31:0] hi,
                            logic [31:0] x);
      qp_item_type it;
      it.op = op; it.row = 4'(row); it.col = 4'(col); it.h = h;
      it.q = q; it.lo = lo; it.hi = hi; it.x = x;
      pending_items.push_back(it);
      items_pushed++;
   endtask

   task automatic push_noise(logic [1:0] op);
      push_item(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // well-formed problem on the first n variables; wild gives full-range values
   task automatic load_problem(int n, bit wild);
      int i, j, lo, hi;
      for (i = 0; i < n; i++) begin
         for (j = 0; j < n; j++) begin
            if (wild)
               push_item(OP_HESS, i, j, $urandom, 0, 0, 0, 0);
            else if (i == j)
               push_item(OP_HESS, i, j, $urandom_range(32'h8000, 32'h40000), 0, 0, 0, 0);
            else
               push_item(OP_HESS, i, j, $urandom_range(0, 32'h8000) - 32'h4000, 0, 0, 0, 0);
         end
         lo = -$urandom_range(0, 32'h60000);
         hi = $urandom_range(0, 32'h60000);
         if ($urandom_range(0, 9) == 0) begin
            lo = $urandom_range(32'h10000, 32'h20000);
            hi = -lo;
         end
         if (wild)
            push_item(OP_VEC, i, 0, 0, $urandom, $urandom, $urandom, $urandom);
         else
            push_item(OP_VEC, i, 0, 0, $urandom_range(0, 32'h80000) - 32'h40000, lo, hi,
                      $urandom_range(0, 32'hc0000) - 32'h60000);
      end
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STEP:  step_cfg = data[30:0];
         CSR_LIMIT: limit_cfg = data[15:0];
         CSR_TOL:   tol_cfg = data[30:0];
         CSR_SIZE:  size_cfg = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_solutions.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_config(logic [31:0] st, logic [31:0] lim, logic [31:0] tol,
                             logic [31:0] sz);
      wait_idle();
      csr_write(CSR_STEP, st);
      csr_write(CSR_LIMIT, lim);
      csr_write(CSR_TOL, tol);
      csr_write(CSR_SIZE, sz);
   endtask

   // request driver: launches on the falling edge, holds until transferred
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            cur_item = pending_items.pop_front();
            req_opcode <= cur_item.op;
            req_row_index <= cur_item.row;
            req_col_index <= cur_item.col;
            req_hessian_value <= cur_item.h;
            req_linear_value <= cur_item.q;
            req_lower_value <= cur_item.lo;
            req_upper_value <= cur_item.hi;
            req_start_value <= cur_item.x;
            req_valid <= 1'b1;
            req_gap = idle_on ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall pattern
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold = idle_on ? pick_gap() : 0;
         end
      end
   end

   // request transfers feed the predictor, result transfers are checked
   always @(posedge clock) begin
      solution_type s;
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1'b1;
         apply_item(cur_item);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_solutions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: var %0d value %0d", rsp_var_index,
                        rsp_solution_value);
         end else begin
            s = expected_solutions.pop_front();
            if (rsp_var_index !== s.idx || rsp_solution_value !== s.val ||
                rsp_last !== s.last || rsp_converged !== s.conv ||
                rsp_iterations !== s.iters) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp var %0d val %0d last %0b conv %0b iter %0d, got var %0d val %0d last %0b conv %0b iter %0d",
                           s.idx, s.val, s.last, s.conv, s.iters, rsp_var_index,
                           rsp_solution_value, rsp_last, rsp_converged, rsp_iterations);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_box_qp_projected_gradient_solver failed");
         $finish;
      end
   end

   initial begin
      int i, j, n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = '0; req_row_index = '0; req_col_index = '0;
      req_hessian_value = '0; req_linear_value = '0; req_lower_value = '0;
      req_upper_value = '0; req_start_value = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      step_cfg = 31'd6554; limit_cfg = 16'd100; tol_cfg = 31'd66; size_cfg = 5'd16;
      req_taken = 1'b0; idle_on = 1'b1; req_gap = 0; rsp_hold = 0;
      mismatches = 0; items_pushed = 0; cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every store first, with full-range content, then solve at reset settings
      load_problem(N_MAX, 1'b1);
      push_item(OP_SOLVE, 0, 0, 0, 0, 0, 0, 0);
      // warm start: solve again without reloading, plus the unused opcode
      push_noise(OP_UNUSED);
      push_item(OP_SOLVE, 0, 0, 0, 0, 0, 0, 0);

      // maximum iteration limit and step on a trivial problem: settles at once
      set_config(32'hffff_ffff, 32'h0000_ffff, 32'h7fff_ffff, 32'd1);
      push_item(OP_HESS, 0, 0, 0, 0, 0, 0, 0);
      push_item(OP_VEC, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678);
      push_item(OP_SOLVE, 0, 0, 0, 0, 0, 0, 0);
      // extreme Hessian and vector values on a single variable
      push_item(OP_HESS, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
      push_item(OP_VEC, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff);
      push_item(OP_SOLVE, 0, 0, 0, 0, 0, 0, 0);

      // zero step and zero size; then zero limit, zero tolerance, oversize
      set_config(32'd0, 32'd7, 32'd1, 32'd0);
      push_item(OP_SOLVE, 0, 0, 0, 0, 0, 0, 0);
      set_config(32'h0000_4000, 32'd0, 32'd0, 32'd31);
      push_item(OP_SOLVE, 0, 0, 0, 0, 0, 0, 0);
      // crossed bounds on variable 1
      set_config(32'h0000_2000, 32'd5, 32'd0, 32'd2);
      push_item(OP_HESS, 1, 1, 32'h7fff_ffff, 0, 0, 0, 0);
      push_item(OP_VEC, 1, 0, 0, 32'h8000_0000, 32'h0002_0000, 32'hfffe_0000, 0);
      push_item(OP_SOLVE, 0, 0, 0, 0, 0, 0, 0);

      // random phases: mostly well-formed problems, some wild ones and noise
      while (items_pushed < 450) begin
         idle_on = ($urandom_range(0, 3) != 0);
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
         set_config(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(32'h800, 32'h8000)
                    | ($urandom & 32'h8000_0000),
                    $urandom_range(0, 40) | ($urandom & 32'hffff_0000),
                    ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3000),
                    n | ($urandom & 32'hffff_ffe0));
         n = (n == 0) ? 1 : ((n > N_MAX) ? N_MAX : n);
         for (i = 0; i < 3 && items_pushed < 450; i++) begin
            j = $urandom_range(0, 9);
            if (j < 6) load_problem(n, 1'b0);
            else if (j < 7) load_problem(n, 1'b1);
            else if (j < 9) push_noise($urandom_range(0, 1) ? OP_VEC : OP_UNUSED);
            push_item(OP_SOLVE, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
         end
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("tb_box_qp_projected_gradient_solver passed");
      else
         $display("tb_box_qp_projected_gradient_solver failed");
      $finish;
   end

endmodule
